@@ sv/sbpp_pkg.sv @@
// Shared constants and types of the servo bus packet parser.
// No dependencies; the top, framer and emitter refer to it by scoped names.
package sbpp_pkg;

  localparam int unsigned MAX_PARAMS = 32;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] LENGTH_BIAS = 8'd2;

  // Start of a result burst, from the framer to the emitter.
  typedef struct packed {
    logic       start;
    logic       empty;
    logic [7:0] id;
    logic [7:0] instr;
    logic [7:0] count;
  } burst_req_t;

endpackage

@@ sv/sbpp_if.sv @@
// Request channels of the servo bus packet parser: received bytes in,
// parsed results out. Valid/ready handshake; no package dependency.
interface sbpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbpp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_id;
  logic [7:0] instruction_code;
  logic [5:0] param_count;
  logic [4:0] param_index;
  logic [7:0] param_byte;
  logic       has_param;
  logic       last;

  modport source (
    output valid, output packet_id, output instruction_code, output param_count,
    output param_index, output param_byte, output has_param, output last,
    input ready
  );
  modport sink (
    input valid, input packet_id, input instruction_code, input param_count,
    input param_index, input param_byte, input has_param, input last,
    output ready
  );
endinterface

@@ sv/servo_bus_packet_parser.sv @@
// Servo bus packet parser: one received byte per request in, one result per
// parameter out, one for a packet with no parameters. Bytes are taken one per
// cycle while no burst is out. A good packet's first result follows its
// checksum byte via the sequencer's read and show states (show only with no
// parameters); later ones pass the read state again for the registered RAM read.
// Reset clears framer and sequencer control, not the RAM or held id/instr/count.
module servo_bus_packet_parser #(
  parameter int unsigned MaxParams = sbpp_pkg::MAX_PARAMS,
  localparam int unsigned AddrW = (MaxParams > 1) ? $clog2(MaxParams) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sbpp_byte_if.sink     req_i,
  sbpp_result_if.source rsp_o
);

  sbpp_pkg::burst_req_t burst;
  logic                 busy;
  logic                 we;
  logic [AddrW-1:0]     waddr;
  logic [7:0]           wdata;
  logic [AddrW-1:0]     raddr;
  logic [7:0]           rdata;

  sbpp_framer #(.MaxParams(MaxParams)) u_framer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .byte_i  (req_i.rx_byte),
    .ready_o (req_i.ready),
    .busy_i  (busy),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .burst_o (burst)
  );

  sbpp_param_ram #(.Depth(MaxParams)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sbpp_emitter #(.MaxParams(MaxParams)) u_emitter (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .burst_i            (burst),
    .busy_o             (busy),
    .raddr_o            (raddr),
    .rdata_i            (rdata),
    .valid_o            (rsp_o.valid),
    .ready_i            (rsp_o.ready),
    .packet_id_o        (rsp_o.packet_id),
    .instruction_code_o (rsp_o.instruction_code),
    .param_count_o      (rsp_o.param_count),
    .param_index_o      (rsp_o.param_index),
    .param_byte_o       (rsp_o.param_byte),
    .has_param_o        (rsp_o.has_param),
    .last_o             (rsp_o.last)
  );

endmodule

@@ sv/sbpp_param_ram.sv @@
// Parameter byte store of the packet parser: one write port, one read port,
// read data registered. Depends on nothing.
module sbpp_param_ram #(
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/sbpp_framer.sv @@
// Byte framing of the packet parser: header hunt, id, length, instruction,
// parameter writes into the store, checksum check. Uses sbpp_pkg.
module sbpp_framer #(
  parameter int unsigned MaxParams = sbpp_pkg::MAX_PARAMS,
  localparam int unsigned AddrW = (MaxParams > 1) ? $clog2(MaxParams) : 1,
  localparam int unsigned CntW  = $clog2(MaxParams + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          byte_i,
  output logic                ready_o,
  input  logic                busy_i,
  output logic                we_o,
  output logic [AddrW-1:0]    waddr_o,
  output logic [7:0]          wdata_o,
  output sbpp_pkg::burst_req_t burst_o
);

  typedef enum logic [5:0] {
    ST_HDR0  = 6'b000001,
    ST_HDR1  = 6'b000010,
    ST_ID    = 6'b000100,
    ST_LEN   = 6'b001000,
    ST_INSTR = 6'b010000,
    ST_BODY  = 6'b100000
  } frame_state_e;

  frame_state_e    state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [7:0]      id_q, id_d;
  logic [7:0]      expected_q, expected_d;
  logic [7:0]      instr_q, instr_d;
  logic [7:0]      sum_q, sum_d;
  logic            accept;
  logic            body_done;
  logic            sum_ok;

  assign ready_o   = ~busy_i;
  assign accept    = valid_i & ready_o;
  assign body_done = 8'(idx_q) >= expected_q;
  assign sum_ok    = (~sum_q) == byte_i;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    id_d       = id_q;
    expected_d = expected_q;
    instr_d    = instr_q;
    sum_d      = sum_q;
    we_o       = 1'b0;
    burst_o    = '{start: 1'b0, empty: (expected_q == 8'd0), id: id_q,
                   instr: instr_q, count: expected_q};
    if (accept) begin
      unique case (state_q)
        ST_HDR0: begin
          if (byte_i == sbpp_pkg::HEADER_BYTE) state_d = ST_HDR1;
        end
        ST_HDR1: begin
          state_d = (byte_i == sbpp_pkg::HEADER_BYTE) ? ST_ID : ST_HDR0;
        end
        ST_ID: begin
          id_d    = byte_i;
          sum_d   = byte_i;
          state_d = ST_LEN;
        end
        ST_LEN: begin
          if (byte_i < sbpp_pkg::LENGTH_BIAS) begin
            state_d = ST_HDR0;
          end else begin
            expected_d = byte_i - sbpp_pkg::LENGTH_BIAS;
            sum_d      = sum_q + byte_i;
            state_d    = ST_INSTR;
          end
        end
        ST_INSTR: begin
          instr_d = byte_i;
          sum_d   = sum_q + byte_i;
          idx_d   = '0;
          state_d = ST_BODY;
        end
        ST_BODY: begin
          priority if (body_done) begin
            burst_o.start = sum_ok;
            state_d       = ST_HDR0;
          end else if (idx_q == CntW'(MaxParams)) begin
            state_d = ST_HDR0;
          end else begin
            we_o  = 1'b1;
            sum_d = sum_q + byte_i;
            idx_d = idx_q + 1'b1;
          end
        end
        default: state_d = ST_HDR0;
      endcase
    end
  end

  assign waddr_o = idx_q[AddrW-1:0];
  assign wdata_o = byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_HDR0;
      idx_q      <= '0;
      id_q       <= '0;
      expected_q <= '0;
      instr_q    <= '0;
      sum_q      <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      id_q       <= id_d;
      expected_q <= expected_d;
      instr_q    <= instr_d;
      sum_q      <= sum_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BODY |-> idx_q <= CntW'(MaxParams))
    else $error("parameter index beyond store");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> !busy_i && 8'(idx_q) < expected_q)
    else $error("store write outside packet body");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_o.start |-> 8'(idx_q) == expected_q && expected_q <= 8'(MaxParams))
    else $error("burst started with wrong parameter count");

endmodule

@@ sv/sbpp_emitter.sv @@
// Result sequencer of the packet parser: reads stored parameters back one
// per result, shown from the store's registered read data. Uses sbpp_pkg.
module sbpp_emitter #(
  parameter int unsigned MaxParams = sbpp_pkg::MAX_PARAMS,
  localparam int unsigned AddrW = (MaxParams > 1) ? $clog2(MaxParams) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbpp_pkg::burst_req_t burst_i,
  output logic                 busy_o,
  output logic [AddrW-1:0]     raddr_o,
  input  logic [7:0]           rdata_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [7:0]           packet_id_o,
  output logic [7:0]           instruction_code_o,
  output logic [5:0]           param_count_o,
  output logic [4:0]           param_index_o,
  output logic [7:0]           param_byte_o,
  output logic                 has_param_o,
  output logic                 last_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SHOW = 3'b100
  } emit_state_e;

  emit_state_e      state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             empty_q, empty_d;
  logic [7:0]       id_q, id_d;
  logic [7:0]       instr_q, instr_d;
  logic [7:0]       count_q, count_d;
  logic             is_last;

  assign is_last = empty_q | ((8'(idx_q) + 8'd1) == count_q);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    empty_d = empty_q;
    id_d    = id_q;
    instr_d = instr_q;
    count_d = count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (burst_i.start) begin
          idx_d   = '0;
          empty_d = burst_i.empty;
          id_d    = burst_i.id;
          instr_d = burst_i.instr;
          count_d = burst_i.count;
          state_d = burst_i.empty ? ST_SHOW : ST_READ;
        end
      end
      ST_READ: state_d = ST_SHOW;
      ST_SHOW: begin
        if (ready_i) begin
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    instr_q <= instr_d;
    count_q <= count_d;
  end

  assign busy_o             = state_q != ST_IDLE;
  assign raddr_o            = idx_q;
  assign valid_o            = state_q == ST_SHOW;
  assign packet_id_o        = id_q;
  assign instruction_code_o = instr_q;
  assign param_count_o      = count_q[5:0];
  assign param_index_o      = 5'(idx_q);
  assign param_byte_o       = empty_q ? 8'd0 : rdata_i;
  assign has_param_o        = ~empty_q;
  assign last_o             = is_last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_i.start |-> state_q == ST_IDLE)
    else $error("burst request while emitting");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ready_i && last_o |=> state_q == ST_IDLE)
    else $error("burst did not end after last result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && has_param_o |-> 8'(idx_q) < count_q)
    else $error("result index beyond parameter count");

endmodule
